// ===== sv/dhpq_pkg.sv =====
// Shared types, constants and helpers for the d-ary heap priority queue.
package dhpq_pkg;

    localparam int CAPACITY_DEF  = 1024;
    localparam int MAX_ARITY_DEF = 8;
    localparam int KEY_W         = 32;
    localparam int CNT_W         = 11;
    localparam int ARITY_W       = 4;

    localparam logic [0:0] OP_INSERT = 1'b0;
    localparam logic [0:0] OP_REMOVE = 1'b1;

    localparam logic [1:0] ST_DONE       = 2'd0;
    localparam logic [1:0] ST_FULL       = 2'd1;
    localparam logic [1:0] ST_EMPTY      = 2'd2;

    localparam logic [0:0] REG_ARITY     = 1'b0;
    localparam logic [0:0] REG_MAX_ORDER = 1'b1;

    typedef struct packed {
        logic [0:0]        operation;
        logic signed [KEY_W-1:0] key;
    } t_in_item;

    typedef struct packed {
        logic signed [KEY_W-1:0] top_key;
        logic                    is_empty;
        logic [CNT_W-1:0]        entry_count;
        logic [1:0]              status;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_CMP,
        S_DN_LAST,
        S_DN_ROOT,
        S_DN_RD,
        S_DN_SCAN,
        S_DN_DEC,
        S_TOP_RD,
        S_TOP_WAIT,
        S_OUT
    } t_state;

    // True when key a belongs strictly above key b.
    function automatic logic ranks_above(input logic signed [KEY_W-1:0] a,
                                         input logic signed [KEY_W-1:0] b,
                                         input logic max_order);
        ranks_above = max_order ? (a > b) : (a < b);
    endfunction

endpackage

// ===== sv/dhpq_ram.sv =====
// Generic single-port synchronous RAM with a registered read.
module dhpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== sv/dary_heap_priority_queue_core.sv =====
// Top level of the d-ary heap priority queue: sequencer around one heap memory.
// Each transfer runs one insert or remove against a single-port heap memory
// (one access per cycle, registered read). An insert reads and compares the
// parent at each level climbed; a remove reads each of the d children through
// the one port at each level descended; the root is then read back for the
// result. One item is worked at a time; the input is stalled while busy and
// while a result waits, and the result register is freed as soon as it is
// transferred. There is no clearing pass after reset.
module dary_heap_priority_queue_core #(
    parameter int CAPACITY  = dhpq_pkg::CAPACITY_DEF,
    parameter int MAX_ARITY = dhpq_pkg::MAX_ARITY_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  dhpq_pkg::t_in_item   i_data,
    output logic                 o_valid,
    input  logic                 i_stall,
    output dhpq_pkg::t_out_item  o_data,
    input  logic                 i_cfg_we,
    input  logic [0:0]           i_cfg_index,
    input  logic [3:0]           i_cfg_data
);
    localparam int AW  = $clog2(CAPACITY);
    localparam int PW  = AW + 1;
    localparam int KW  = dhpq_pkg::KEY_W;
    localparam int RK  = AW + 8;

    dhpq_pkg::t_state r_state, n_state;
    logic [3:0]   r_arity;
    logic         r_max_order;
    logic [PW-1:0] r_fill, n_fill;
    logic [PW-1:0] r_pos, n_pos;       // index of the moving entry
    logic [PW-1:0] r_idx, n_idx;       // index being scanned / parent
    logic [PW-1:0] r_best, n_best;
    logic [3:0]    r_k, n_k;
    logic signed [KW-1:0] r_here, n_here;
    logic signed [KW-1:0] r_bkey, n_bkey;
    logic [1:0]    r_status, n_status;
    dhpq_pkg::t_out_item r_out, n_out;
    logic          r_oval, n_oval;

    logic          mem_we;
    logic [AW-1:0] mem_addr;
    logic [KW-1:0] mem_wdata, mem_rdata;
    logic signed [KW-1:0] rkey;
    logic [3:0]    d;
    logic [PW+3:0] first_wide;
    logic [PW-1:0] parent;
    logic [RK-1:0] recip_tab [16];
    logic [PW+RK-1:0] parent_prod;

    dhpq_ram #(.WIDTH(KW), .DEPTH(CAPACITY)) u_heap (
        .i_clk(i_clk), .i_we(mem_we), .i_addr(mem_addr),
        .i_wdata(mem_wdata), .o_rdata(mem_rdata)
    );

    // Rounded-up reciprocal of each arity, exact for every index below capacity.
    for (genvar g = 0; g < 16; g++) begin : g_recip
        localparam int RV = (g < 2) ? 0 : ((1 << RK) + g - 1) / g;
        assign recip_tab[g] = RK'(RV);
    end

    assign rkey  = $signed(mem_rdata);
    assign d     = (r_arity < 4'd2) ? 4'd2 :
                   (({1'b0, r_arity} > 5'(MAX_ARITY)) ? 4'(MAX_ARITY) : r_arity);
    // Parent index by multiplying with the reciprocal of the arity.
    assign parent_prod = (PW+RK)'(r_pos - PW'(1)) * (PW+RK)'(recip_tab[d]);
    assign parent      = parent_prod[PW+RK-1:RK];
    assign first_wide = (PW+4)'(r_pos) * (PW+4)'(d) + (PW+4)'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_arity     <= 4'd2;
            r_max_order <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                dhpq_pkg::REG_ARITY:     r_arity     <= i_cfg_data;
                dhpq_pkg::REG_MAX_ORDER: r_max_order <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dhpq_pkg::S_IDLE;
            r_fill  <= '0;
            r_oval  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_oval  <= n_oval;
        end
        r_pos <= n_pos; r_idx <= n_idx; r_best <= n_best; r_k <= n_k;
        r_here <= n_here; r_bkey <= n_bkey; r_status <= n_status; r_out <= n_out;
    end

    logic accept_in;
    assign accept_in = i_valid && !o_stall;
    assign o_stall   = (r_state != dhpq_pkg::S_IDLE) || r_oval;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dhpq_pkg::S_IDLE: begin
                if (accept_in) begin
                    if (i_data.operation == dhpq_pkg::OP_INSERT) begin
                        n_state = (r_fill >= PW'(CAPACITY)) ? dhpq_pkg::S_TOP_RD
                                                           : dhpq_pkg::S_UP_RD;
                    end else begin
                        n_state = (r_fill == '0) ? dhpq_pkg::S_TOP_RD
                                                 : dhpq_pkg::S_DN_LAST;
                    end
                end
            end
            dhpq_pkg::S_UP_RD:   n_state = (r_pos == '0) ? dhpq_pkg::S_TOP_RD
                                                          : dhpq_pkg::S_UP_CMP;
            dhpq_pkg::S_UP_CMP:  n_state = dhpq_pkg::ranks_above(r_here, rkey, r_max_order)
                                           ? dhpq_pkg::S_UP_RD : dhpq_pkg::S_TOP_RD;
            dhpq_pkg::S_DN_LAST: n_state = dhpq_pkg::S_DN_ROOT;
            dhpq_pkg::S_DN_ROOT: n_state = dhpq_pkg::S_DN_RD;
            dhpq_pkg::S_DN_RD:   n_state = (first_wide >= (PW+4)'(r_fill))
                                           ? dhpq_pkg::S_TOP_RD : dhpq_pkg::S_DN_SCAN;
            dhpq_pkg::S_DN_SCAN: begin
                if ((r_k + 4'd1 >= d) ||
                    ((PW+1)'(r_idx) + (PW+1)'(1) >= (PW+1)'(r_fill))) begin
                    n_state = dhpq_pkg::S_DN_DEC;
                end
            end
            dhpq_pkg::S_DN_DEC:  n_state = dhpq_pkg::S_DN_RD;
            dhpq_pkg::S_TOP_RD:  n_state = dhpq_pkg::S_TOP_WAIT;
            dhpq_pkg::S_TOP_WAIT: n_state = dhpq_pkg::S_OUT;
            dhpq_pkg::S_OUT:     n_state = dhpq_pkg::S_IDLE;
            default:             n_state = dhpq_pkg::S_IDLE;
        endcase
        // Decision stage of a sift-down step may end the walk.
        if (r_state == dhpq_pkg::S_DN_DEC &&
            !dhpq_pkg::ranks_above(r_bkey, r_here, r_max_order)) begin
            n_state = dhpq_pkg::S_TOP_RD;
        end
    end

    // Datapath and memory control.
    always_comb begin
        logic signed [KW-1:0] cand;
        cand      = rkey;
        n_fill    = r_fill;
        n_pos     = r_pos;
        n_idx     = r_idx;
        n_best    = r_best;
        n_k       = r_k;
        n_here    = r_here;
        n_bkey    = r_bkey;
        n_status  = r_status;
        n_out     = r_out;
        n_oval    = r_oval && i_stall;
        mem_we    = 1'b0;
        mem_addr  = AW'(r_pos);
        mem_wdata = r_here;
        unique case (r_state)
            dhpq_pkg::S_IDLE: begin
                n_status = dhpq_pkg::ST_DONE;
                if (accept_in) begin
                    if (i_data.operation == dhpq_pkg::OP_INSERT) begin
                        if (r_fill >= PW'(CAPACITY)) begin
                            n_status = dhpq_pkg::ST_FULL;
                        end else begin
                            mem_we    = 1'b1;
                            mem_addr  = AW'(r_fill);
                            mem_wdata = i_data.key;
                            n_here    = i_data.key;
                            n_pos     = r_fill;
                            n_fill    = r_fill + PW'(1);
                        end
                    end else if (r_fill == '0) begin
                        n_status = dhpq_pkg::ST_EMPTY;
                    end else begin
                        n_fill   = r_fill - PW'(1);
                        mem_addr = AW'(r_fill - PW'(1));
                    end
                end
            end
            dhpq_pkg::S_UP_RD: begin
                mem_addr = AW'(parent);
                n_idx    = parent;
            end
            dhpq_pkg::S_UP_CMP: begin
                // The entry holds r_here; swap with the parent when it ranks above.
                if (dhpq_pkg::ranks_above(r_here, rkey, r_max_order)) begin
                    mem_we    = 1'b1;
                    mem_addr  = AW'(r_pos);
                    mem_wdata = rkey;
                    n_pos     = r_idx;
                end
            end
            dhpq_pkg::S_DN_LAST: begin
                // Keep reading the last entry so its key is still on the bus next cycle.
                mem_addr = AW'(r_fill);
            end
            dhpq_pkg::S_DN_ROOT: begin
                // Last entry's key is now valid; it becomes the moving root.
                n_here    = rkey;
                mem_we    = 1'b1;
                mem_addr  = '0;
                mem_wdata = rkey;
                n_pos     = '0;
            end
            dhpq_pkg::S_DN_RD: begin
                mem_addr = AW'(first_wide);
                n_idx    = PW'(first_wide);
                n_best   = PW'(first_wide);
                n_k      = 4'd0;
            end
            dhpq_pkg::S_DN_SCAN: begin
                // Data for child r_idx arrives; issue read of the next child.
                if (r_k == 4'd0 || dhpq_pkg::ranks_above(cand, r_bkey, r_max_order)) begin
                    n_bkey = cand;
                    n_best = r_idx;
                end
                n_idx    = r_idx + PW'(1);
                n_k      = r_k + 4'd1;
                mem_addr = AW'(r_idx + PW'(1));
            end
            dhpq_pkg::S_DN_DEC: begin
                if (dhpq_pkg::ranks_above(r_bkey, r_here, r_max_order)) begin
                    mem_we    = 1'b1;
                    mem_addr  = AW'(r_pos);
                    mem_wdata = r_bkey;
                    n_pos     = r_best;
                end
            end
            dhpq_pkg::S_TOP_RD: begin
                // Close the moving entry at its final slot, then read the root.
                if (r_status == dhpq_pkg::ST_DONE) begin
                    mem_we    = 1'b1;
                    mem_addr  = AW'(r_pos);
                    mem_wdata = r_here;
                end
            end
            dhpq_pkg::S_TOP_WAIT: begin
                mem_addr = '0;
            end
            dhpq_pkg::S_OUT: begin
                n_out.top_key     = (r_fill != '0) ? rkey : '0;
                n_out.is_empty    = (r_fill == '0);
                n_out.entry_count = dhpq_pkg::CNT_W'(r_fill);
                n_out.status      = r_status;
                n_oval            = 1'b1;
            end
            default: ;
        endcase
    end

    assign o_valid = r_oval;
    assign o_data  = r_out;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= PW'(CAPACITY)) else $error("fill count above capacity");
    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != dhpq_pkg::S_IDLE) |-> o_stall) else $error("input open while busy");
    a_out_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dhpq_pkg::S_OUT) |=> o_valid) else $error("result not raised");
`endif
endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the d-ary heap priority queue core.
`timescale 1ns / 100ps

module testbench;
    import dhpq_pkg::*;

    localparam int DEPTH = 1024;
    localparam int MAXD = 8;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    t_in_item i_data = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    t_out_item o_data;
    logic i_cfg_we = 1'b0;
    logic [0:0] i_cfg_index = REG_ARITY;
    logic [3:0] i_cfg_data = '0;

    dary_heap_priority_queue_core dut (.*);

    // Predictor state.
    logic signed [31:0] heap_keys [DEPTH];
    int unsigned heap_fill = 0;
    logic [3:0] arity_reg = 4'd2;
    logic order_max = 1'b0;

    t_in_item pending_items [$];
    t_out_item expected_tops [$];
    int error_count = 0;
    bit idle_ok = 1'b1;
    bit hold_sender = 1'b0;

    // Accept status sampled at the rising edge.
    logic o_stall_q = 1'b1;

    function automatic bit beats(input logic signed [31:0] a, input logic signed [31:0] b);
        return order_max ? (a > b) : (a < b);
    endfunction

    function automatic int unsigned live_arity();
        if (arity_reg < 2) return 2;
        if (arity_reg > MAXD) return MAXD;
        return arity_reg;
    endfunction

    // Applies one operation to the model heap and returns the expected result.
    function automatic t_out_item heap_apply(input t_in_item it);
        t_out_item r;
        int unsigned d, pos, up, first, best;
        logic signed [31:0] tmp;
        d = live_arity();
        r.status = ST_DONE;
        if (it.operation == OP_INSERT) begin
            if (heap_fill >= DEPTH) begin
                r.status = ST_FULL;
            end else begin
                pos = heap_fill;
                heap_keys[pos] = it.key;
                while (pos > 0) begin
                    up = (pos - 1) / d;
                    if (!beats(heap_keys[pos], heap_keys[up])) break;
                    tmp = heap_keys[pos];
                    heap_keys[pos] = heap_keys[up];
                    heap_keys[up] = tmp;
                    pos = up;
                end
                heap_fill++;
            end
        end else begin
            if (heap_fill == 0) begin
                r.status = ST_EMPTY;
            end else begin
                heap_fill--;
                heap_keys[0] = heap_keys[heap_fill];
                pos = 0;
                forever begin
                    first = d * pos + 1;
                    if (first >= heap_fill) break;
                    best = first;
                    for (int k = 1; k < d && first + k < heap_fill; k++)
                        if (beats(heap_keys[first + k], heap_keys[best])) best = first + k;
                    if (!beats(heap_keys[best], heap_keys[pos])) break;
                    tmp = heap_keys[pos];
                    heap_keys[pos] = heap_keys[best];
                    heap_keys[best] = tmp;
                    pos = best;
                end
            end
        end
        r.top_key = heap_fill ? heap_keys[0] : '0;
        r.is_empty = (heap_fill == 0);
        r.entry_count = heap_fill[10:0];
        return r;
    endfunction

    initial forever #5 i_clk = ~i_clk;

    always @(posedge i_clk) o_stall_q <= o_stall;

    // Driver: presents queued items, with random gaps and output stalls while idle_ok is set.
    always @(negedge i_clk) begin
        if (i_valid && !o_stall_q) begin
            expected_tops.push_back(heap_apply(i_data));
        end
        if (i_valid && o_stall_q) begin
            // Hold the stalled transfer.
        end else if (pending_items.size() > 0 && !hold_sender && i_rst_n &&
                     !(idle_ok && $urandom_range(99) < 27)) begin
            i_valid <= 1'b1;
            i_data <= pending_items.pop_front();
        end else begin
            i_valid <= 1'b0;
        end
        i_stall <= idle_ok && ($urandom_range(99) < 27);
    end

    // Monitor: compares each result transfer with the oldest expectation.
    always @(posedge i_clk) begin
        t_out_item e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_tops.size() == 0) begin
                $error("unexpected result %p", o_data);
                error_count++;
            end else begin
                e = expected_tops.pop_front();
                if (o_data.top_key !== e.top_key) begin
                    $error("top_key exp %0d got %0d", e.top_key, o_data.top_key);
                    error_count++;
                end
                if (o_data.is_empty !== e.is_empty) begin
                    $error("is_empty exp %0d got %0d", e.is_empty, o_data.is_empty);
                    error_count++;
                end
                if (o_data.entry_count !== e.entry_count) begin
                    $error("entry_count exp %0d got %0d", e.entry_count, o_data.entry_count);
                    error_count++;
                end
                if (o_data.status !== e.status) begin
                    $error("status exp %0d got %0d", e.status, o_data.status);
                    error_count++;
                end
            end
        end
    end

    function automatic t_in_item mk(input logic [0:0] op, input logic signed [31:0] k);
        t_in_item it;
        it.operation = op;
        it.key = k;
        return it;
    endfunction

    function automatic logic signed [31:0] rand_key();
        case ($urandom_range(3))
            0: return $urandom_range(15) - 8;
            1: return {1'b1, 31'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    task automatic drain();
        while (pending_items.size() > 0 || i_valid || expected_tops.size() > 0)
            @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [3:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_ARITY) arity_reg = val;
        else order_max = val[0];
    endtask

    // Fills with a random mix, biased toward inserts or removes.
    task automatic queue_random(input int n, input int insert_pct);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < insert_pct) pending_items.push_back(mk(OP_INSERT, rand_key()));
            else pending_items.push_back(mk(OP_REMOVE, $urandom));
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        // Directed: remove when empty, key extremes, ties, every operation.
        pending_items.push_back(mk(OP_REMOVE, 32'hFFFF_FFFF));
        pending_items.push_back(mk(OP_INSERT, 32'sh7FFF_FFFF));
        pending_items.push_back(mk(OP_INSERT, 32'sh8000_0000));
        pending_items.push_back(mk(OP_INSERT, 0));
        pending_items.push_back(mk(OP_INSERT, 0));
        pending_items.push_back(mk(OP_INSERT, -1));
        pending_items.push_back(mk(OP_INSERT, 32'h5555_5555));
        pending_items.push_back(mk(OP_INSERT, 32'hAAAA_AAAA));
        for (int i = 0; i < 8; i++) pending_items.push_back(mk(OP_REMOVE, 0));
        drain();

        // Several settings, including out-of-range arity values.
        write_reg(REG_MAX_ORDER, 4'd1);
        write_reg(REG_ARITY, 4'd0);
        queue_random(30, 60);
        drain();
        write_reg(REG_ARITY, 4'd15);
        write_reg(REG_MAX_ORDER, 4'd0);
        queue_random(30, 55);
        drain();
        write_reg(REG_ARITY, 4'd3);
        idle_ok = 1'b0;
        queue_random(80, 50);
        drain();
        idle_ok = 1'b1;

        // Fill to capacity with refused inserts, then remove a few.
        write_reg(REG_ARITY, 4'd8);
        write_reg(REG_MAX_ORDER, 4'd1);
        queue_random(DEPTH + 4, 100);
        queue_random(20, 0);
        // Sender holds until every outstanding result has come back.
        while (pending_items.size() > 600) @(posedge i_clk);
        hold_sender = 1'b1;
        while (i_valid || expected_tops.size() > 0) @(posedge i_clk);
        hold_sender = 1'b0;
        drain();

        if (error_count == 0) $display("end of test: clean");
        else $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #20ms;
        $display("end of test: mismatches");
        $finish;
    end
endmodule
